@@ design/linear_brightness_fade_macros.svh @@
// assertion macros for the linear brightness fade block
// used by the back-end module, no other dependencies
`ifndef LINEAR_BRIGHTNESS_FADE_MACROS_SVH
`define LINEAR_BRIGHTNESS_FADE_MACROS_SVH
`ifndef SYNTHESIS
`define LBF_ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("lbf assertion failed");
`define LBF_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("lbf assertion failed");
`else
`define LBF_ASSERT_IMPL(label, clk, rst_n, a, c)
`define LBF_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ design/lbf_pkg.sv @@
// shared types and constants for the linear brightness fade block
// no dependencies
package lbf_pkg;

    localparam logic [7:0] MODE_UP    = 8'h80;
    localparam logic [7:0] MODE_DOWN  = 8'hC0;
    localparam logic [4:0] LEVEL_MAX  = 5'h10;
    localparam logic       KIND_TICK  = 1'b0;
    localparam logic       KIND_START = 1'b1;

    localparam int MAG_W       = 13;
    localparam int DIV_STEPS   = MAG_W;
    localparam int CNT_W       = $clog2(DIV_STEPS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0]       ctrl;
        logic [4:0]       to_level;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [7:0]       total;
        logic             done;
    } job_t;

    typedef struct packed {
        logic [7:0] ctrl;
        logic [4:0] level;
        logic       done;
    } result_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

@@ design/lbf_front.sv @@
// front end: accepts items, holds the fade state, builds divide jobs
// depends on lbf_pkg
module lbf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic          kind,
    input  logic          brighten,
    input  logic [5:0]    layer_mask,
    input  logic [4:0]    start_level,
    input  logic [4:0]    target_level,
    input  logic [7:0]    duration,
    input  lbf_pkg::qstat_t q_stat,
    output logic          job_push,
    output lbf_pkg::job_t job
);
    import lbf_pkg::*;

    logic       dir_up_reg, dir_up_next;
    logic [5:0] mask_reg, mask_next;
    logic [4:0] from_reg, from_next;
    logic [4:0] to_reg, to_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] left_reg, left_next;

    logic       accept;
    logic [7:0] left_dec;
    logic [5:0] diff;
    logic [5:0] abs_diff;

    assign accept   = push && !q_stat.full;
    assign left_dec = left_reg - 8'd1;
    assign diff     = {1'b0, from_reg} - {1'b0, to_reg};
    assign abs_diff = diff[5] ? (6'd0 - diff) : diff;
    assign job_push = accept && (kind == KIND_TICK) && (total_reg != 8'd0);

    always_comb
    begin
        job.ctrl     = {2'b00, mask_reg} | (dir_up_reg ? MODE_UP : MODE_DOWN);
        job.to_level = to_reg;
        job.neg      = diff[5];
        job.mag      = {{(MAG_W-5){1'b0}}, abs_diff[4:0]} * {{(MAG_W-8){1'b0}}, left_dec};
        job.total    = total_reg;
        job.done     = (left_dec == 8'd0);
    end

    always_comb
    begin
        dir_up_next = dir_up_reg;
        mask_next   = mask_reg;
        from_next   = from_reg;
        to_next     = to_reg;
        total_next  = total_reg;
        left_next   = left_reg;
        if (accept && (kind == KIND_START))
        begin
            dir_up_next = brighten;
            mask_next   = layer_mask;
            from_next   = (start_level > LEVEL_MAX) ? to_reg : start_level;
            to_next     = target_level;
            total_next  = duration;
            left_next   = duration;
        end
        else if (job_push)
        begin
            left_next = left_dec;
            if (left_dec == 8'd0)
            begin
                total_next = 8'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_up_reg <= 1'b0;
            mask_reg   <= 6'd0;
            from_reg   <= 5'd0;
            to_reg     <= 5'd0;
            total_reg  <= 8'd0;
            left_reg   <= 8'd0;
        end
        else
        begin
            dir_up_reg <= dir_up_next;
            mask_reg   <= mask_next;
            from_reg   <= from_next;
            to_reg     <= to_next;
            total_reg  <= total_next;
            left_reg   <= left_next;
        end
    end

endmodule

@@ design/lbf_queue.sv @@
// short job queue between front and back end
// depends on lbf_pkg
module lbf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  lbf_pkg::job_t   wr_data,
    input  logic            rd_en,
    output lbf_pkg::job_t   rd_data,
    output lbf_pkg::qstat_t stat
);
    import lbf_pkg::*;

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_wr, do_rd;

    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ design/lbf_back.sv @@
// back end: serial restoring divider and result register
// depends on lbf_pkg and linear_brightness_fade_macros.svh
`include "linear_brightness_fade_macros.svh"
module lbf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lbf_pkg::qstat_t q_stat,
    input  lbf_pkg::job_t   q_data,
    output logic            q_pop,
    input  logic            pop,
    output logic            res_valid,
    output lbf_pkg::result_t res
);
    import lbf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]       rem_reg, rem_next;
    logic [MAG_W-1:0] quo_reg, quo_next;
    job_t             job_reg, job_next;
    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;

    logic       out_free;
    logic [8:0] trial;
    logic       fits;
    logic [4:0] q5;

    assign out_free  = !out_valid_reg || pop;
    assign q_pop     = (state_reg == ST_IDLE) && !q_stat.empty;
    assign trial     = {rem_reg, quo_reg[MAG_W-1]};
    assign fits      = (trial >= {1'b0, job_reg.total});
    assign q5        = quo_reg[4:0];
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        job_next       = job_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && pop)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    job_next   = q_data;
                    quo_next   = q_data.mag;
                    rem_next   = 8'd0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = fits ? 8'(trial - {1'b0, job_reg.total}) : trial[7:0];
                quo_next = {quo_reg[MAG_W-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_next.ctrl  = job_reg.ctrl;
                    out_next.level = job_reg.neg ? (job_reg.to_level - q5)
                                                 : (job_reg.to_level + q5);
                    out_next.done  = job_reg.done;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_reg       <= '0;
            quo_reg       <= '0;
            job_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_reg       <= rem_next;
            quo_reg       <= quo_next;
            job_reg       <= job_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    `LBF_ASSERT_IMPL(a_div_count, clk, rst_n, state_reg == ST_DIV, cnt_reg < CNT_W'(DIV_STEPS))
    `LBF_ASSERT_IMPL(a_rem_below, clk, rst_n, state_reg == ST_DIV, rem_reg < job_reg.total)
    `LBF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && !pop,
        out_valid_reg && $stable(out_reg))
    `LBF_ASSERT_NEXT(a_wait_out, clk, rst_n, state_reg == ST_HOLD && !out_free,
        state_reg == ST_HOLD)

endmodule

@@ design/linear_brightness_fade.sv @@
// top level of the linear brightness fade block
// path: a result-bearing tick goes through the job queue, divider and result register
// back end: a new job starts only after the 13-step divider's last result is registered
// start items and idle ticks do not reach the queue and wait only while the job queue is full
// two-entry job queue lets the front take items while the back end divides
// reset: asynchronous, active low, fade idle, job queue and result register empty
module linear_brightness_fade (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic       kind,
    input  logic       brighten,
    input  logic [5:0] layer_mask,
    input  logic [4:0] start_level,
    input  logic [4:0] target_level,
    input  logic [7:0] duration,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] blend_control,
    output logic [4:0] brightness,
    output logic       finished
);
    import lbf_pkg::*;

    qstat_t  q_stat;
    job_t    job_in;
    job_t    job_out;
    logic    job_push;
    logic    q_pop;
    logic    res_valid;
    result_t res;

    lbf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .kind         (kind),
        .brighten     (brighten),
        .layer_mask   (layer_mask),
        .start_level  (start_level),
        .target_level (target_level),
        .duration     (duration),
        .q_stat       (q_stat),
        .job_push     (job_push),
        .job          (job_in)
    );

    lbf_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (q_pop),
        .rd_data (job_out),
        .stat    (q_stat)
    );

    lbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_data    (job_out),
        .q_pop     (q_pop),
        .pop       (pop),
        .res_valid (res_valid),
        .res       (res)
    );

    assign full          = q_stat.full;
    assign empty         = !res_valid;
    assign blend_control = res.ctrl;
    assign brightness    = res.level;
    assign finished      = res.done;

endmodule
